### src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, constants, register map and types of the pump pressure
// controller.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int TIME_W = 32;
  localparam int PCT_W  = 7;
  localparam int MBAR_W = 14;
  localparam int MV_W   = 13;
  localparam int P100_W = 21;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  // Register map, index = paddr / 4
  localparam logic [IDX_W-1:0] REG_LOWER_PCT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_UPPER_PCT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_QUIET_DELAY = 3'd2;
  localparam logic [IDX_W-1:0] REG_LEAK_PERIOD = 3'd3;
  localparam logic [IDX_W-1:0] REG_LEAK_DROP   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAL_IDLE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAL_LIMIT   = 3'd6;

  localparam logic [PCT_W-1:0]  LOWER_PCT_RST   = 7'd40;
  localparam logic [PCT_W-1:0]  UPPER_PCT_RST   = 7'd60;
  localparam logic [TIME_W-1:0] QUIET_DELAY_RST = 32'd5000;
  localparam logic [TIME_W-1:0] LEAK_PERIOD_RST = 32'd60000;
  localparam logic [MBAR_W-1:0] LEAK_DROP_RST   = 14'd100;
  localparam logic [TIME_W-1:0] CAL_IDLE_RST    = 32'd5000;
  localparam logic [TIME_W-1:0] CAL_LIMIT_RST   = 32'd30000;

  // Sensor front end: 3.3 V reference times 1.5 divider = 4950 mV full code
  localparam longint unsigned MV_SPAN = 4950;
  localparam logic [MV_W-1:0] MV_LO   = 13'd300;
  localparam logic [MV_W-1:0] MV_HI   = 13'd4800;
  localparam logic [MV_W-1:0] MV_OFS  = 13'd500;

  // Full scale = peak * 102 / 100 = peak * 51 / 50, by reciprocal
  localparam int FS_SHIFT = 20;
  localparam longint unsigned FS_K = ((64'd51 << FS_SHIFT) + 64'd49) / 64'd50;
  localparam int FS_K_W = 21;
  localparam logic [MBAR_W-1:0] MBAR_MAX = 14'h3FFF;

  localparam logic [PCT_W-1:0] FULL_PCT = 7'd98;

  typedef struct packed {
    logic [PCT_W-1:0]  lower_pct;
    logic [PCT_W-1:0]  upper_pct;
    logic [TIME_W-1:0] quiet_delay_ms;
    logic [TIME_W-1:0] leak_period_ms;
    logic [MBAR_W-1:0] leak_drop_mbar;
    logic [TIME_W-1:0] cal_idle_ms;
    logic [TIME_W-1:0] cal_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] now_ms;
    logic              fault;
    logic [MBAR_W-1:0] pressure;
    logic [P100_W-1:0] pressure_x100;
    logic [MBAR_W-1:0] pressure_fs;
  } conv_t;

endpackage

### src/ppc_if.sv
// ----------------------------------------------------------------------------
// ppc_if
// Request and result channels of the pump pressure controller.
// ----------------------------------------------------------------------------
interface ppc_in_if
  import ppc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SAMPLE_BITS-1:0] raw_sample;
  logic [TIME_W-1:0]      now_ms;

  modport source (output valid, mode, raw_sample, now_ms, input ready);
  modport sink   (input valid, mode, raw_sample, now_ms, output ready);
endinterface

interface ppc_out_if
  import ppc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              pump_on;
  logic              valve_open;
  logic              in_use;
  logic              leak_alarm;
  logic              calibrating;
  logic              sensor_fault;
  logic [MBAR_W-1:0] pressure_mbar;
  logic [MBAR_W-1:0] full_scale_mbar;

  modport source (output valid, pump_on, valve_open, in_use, leak_alarm, calibrating,
                  sensor_fault, pressure_mbar, full_scale_mbar, input ready);
  modport sink   (input valid, pump_on, valve_open, in_use, leak_alarm, calibrating,
                  sensor_fault, pressure_mbar, full_scale_mbar, output ready);
endinterface

### src/ppc_cfg.sv
// ----------------------------------------------------------------------------
// ppc_cfg
// APB register file holding the controller thresholds and timeouts.
// ----------------------------------------------------------------------------
module ppc_cfg
  import ppc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [PCT_W-1:0]  lower_pct;
  logic [PCT_W-1:0]  upper_pct;
  logic [TIME_W-1:0] quiet_delay_ms;
  logic [TIME_W-1:0] leak_period_ms;
  logic [MBAR_W-1:0] leak_drop_mbar;
  logic [TIME_W-1:0] cal_idle_ms;
  logic [TIME_W-1:0] cal_limit_ms;
  logic [IDX_W-1:0]  idx;
  logic              wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_pct      <= LOWER_PCT_RST;
      upper_pct      <= UPPER_PCT_RST;
      quiet_delay_ms <= QUIET_DELAY_RST;
      leak_period_ms <= LEAK_PERIOD_RST;
      leak_drop_mbar <= LEAK_DROP_RST;
      cal_idle_ms    <= CAL_IDLE_RST;
      cal_limit_ms   <= CAL_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOWER_PCT:   lower_pct      <= pwdata[PCT_W-1:0];
        REG_UPPER_PCT:   upper_pct      <= pwdata[PCT_W-1:0];
        REG_QUIET_DELAY: quiet_delay_ms <= pwdata[TIME_W-1:0];
        REG_LEAK_PERIOD: leak_period_ms <= pwdata[TIME_W-1:0];
        REG_LEAK_DROP:   leak_drop_mbar <= pwdata[MBAR_W-1:0];
        REG_CAL_IDLE:    cal_idle_ms    <= pwdata[TIME_W-1:0];
        REG_CAL_LIMIT:   cal_limit_ms   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOWER_PCT:   prdata = {{(DATA_W-PCT_W){1'b0}}, lower_pct};
      REG_UPPER_PCT:   prdata = {{(DATA_W-PCT_W){1'b0}}, upper_pct};
      REG_QUIET_DELAY: prdata = quiet_delay_ms;
      REG_LEAK_PERIOD: prdata = leak_period_ms;
      REG_LEAK_DROP:   prdata = {{(DATA_W-MBAR_W){1'b0}}, leak_drop_mbar};
      REG_CAL_IDLE:    prdata = cal_idle_ms;
      REG_CAL_LIMIT:   prdata = cal_limit_ms;
      default:         prdata = '0;
    endcase
  end

  assign cfg.lower_pct      = lower_pct;
  assign cfg.upper_pct      = upper_pct;
  assign cfg.quiet_delay_ms = quiet_delay_ms;
  assign cfg.leak_period_ms = leak_period_ms;
  assign cfg.leak_drop_mbar = leak_drop_mbar;
  assign cfg.cal_idle_ms    = cal_idle_ms;
  assign cfg.cal_limit_ms   = cal_limit_ms;

endmodule

### src/ppc_conv.sv
// ----------------------------------------------------------------------------
// ppc_conv
// Request register and sample conversion pipeline: code to millivolts,
// fault window, millibar, and the scaled values used downstream.
// ----------------------------------------------------------------------------
module ppc_conv
  import ppc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
  input  logic       clk,
  input  logic       rst,
  ppc_in_if.sink     sample,
  output logic       item_valid,
  input  logic       item_ready,
  output conv_t      item
);

  localparam longint unsigned MAX_CODE = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam int              MV_SHIFT = 2 * SAMPLE_BITS + 1;
  localparam int              MV_K_W   = SAMPLE_BITS + 14;
  localparam int              MV_PROD_W = SAMPLE_BITS + MV_K_W;
  localparam longint unsigned MV_K =
    ((MV_SPAN << MV_SHIFT) + MAX_CODE - 64'd1) / MAX_CODE;
  localparam int FS_PROD_W = MBAR_W + FS_K_W;

  logic                   s1_valid;
  logic                   s1_mode;
  logic [SAMPLE_BITS-1:0] s1_raw;
  logic [TIME_W-1:0]      s1_now;

  logic                   s2_valid;
  logic                   s2_mode;
  logic [TIME_W-1:0]      s2_now;
  logic [MV_W-1:0]        s2_mv;

  logic                   s1_free;
  logic                   s2_free;
  logic                   s3_free;

  logic [MV_PROD_W-1:0]   mv_prod;
  logic [MV_W-1:0]        mv;
  logic                   mv_bad;
  logic [MV_W-1:0]        mv_ofs;
  logic [MBAR_W-1:0]      p;
  logic [FS_PROD_W-1:0]   fs_prod;
  logic [MBAR_W:0]        fs_raw;
  conv_t                  s3_next;

  assign s3_free = !item_valid || item_ready;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign sample.ready = s1_free;

  assign mv_prod = {{MV_K_W{1'b0}}, s1_raw} * {{SAMPLE_BITS{1'b0}}, MV_K[MV_K_W-1:0]};
  assign mv      = mv_prod[MV_SHIFT+MV_W-1:MV_SHIFT];

  assign mv_bad  = (s2_mv < MV_LO) || (s2_mv > MV_HI);
  assign mv_ofs  = s2_mv - MV_OFS;

  always_comb begin
    if (s2_mode || mv_bad || (s2_mv <= MV_OFS)) begin
      p = '0;
    end else begin
      p = {1'b0, mv_ofs} + {mv_ofs, 1'b0};
    end
  end

  assign fs_prod = {{FS_K_W{1'b0}}, p} * {{MBAR_W{1'b0}}, FS_K[FS_K_W-1:0]};
  assign fs_raw  = fs_prod[FS_SHIFT+MBAR_W:FS_SHIFT];

  always_comb begin
    s3_next.mode          = s2_mode;
    s3_next.now_ms        = s2_now;
    s3_next.fault         = !s2_mode && mv_bad;
    s3_next.pressure      = p;
    s3_next.pressure_x100 = {{(P100_W-MBAR_W){1'b0}}, p} * P100_W'(100);
    s3_next.pressure_fs   = fs_raw[MBAR_W] ? MBAR_MAX : fs_raw[MBAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= sample.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        item_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && sample.valid) begin
      s1_mode <= sample.mode;
      s1_raw  <= sample.raw_sample;
      s1_now  <= sample.now_ms;
    end
    if (s2_free && s1_valid) begin
      s2_mode <= s1_mode;
      s2_now  <= s1_now;
      s2_mv   <= mv;
    end
    if (s3_free && s2_valid) begin
      item <= s3_next;
    end
  end

endmodule

### src/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl
// Controller state: calibration, usage, standby valve and leak rules, with
// the result register.
// ----------------------------------------------------------------------------
module ppc_ctrl
  import ppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  output logic       item_ready,
  input  conv_t      item,
  ppc_out_if.source  result
);

  logic              pump_state;
  logic              valve_state;
  logic              use_state;
  logic              leak_state;
  logic              cal_state;
  logic [MBAR_W-1:0] full_scale;
  logic [MBAR_W-1:0] peak_pressure;
  logic [MBAR_W-1:0] peak_fs;
  logic [TIME_W-1:0] last_use_time;
  logic [TIME_W-1:0] cal_start_time;
  logic [TIME_W-1:0] last_rise_time;
  logic [TIME_W-1:0] leak_check_time;
  logic [MBAR_W-1:0] leak_check_pressure;

  logic              pump_state_next;
  logic              valve_state_next;
  logic              use_state_next;
  logic              leak_state_next;
  logic              cal_state_next;
  logic [MBAR_W-1:0] full_scale_next;
  logic [MBAR_W-1:0] peak_pressure_next;
  logic [MBAR_W-1:0] peak_fs_next;
  logic [TIME_W-1:0] last_use_time_next;
  logic [TIME_W-1:0] cal_start_time_next;
  logic [TIME_W-1:0] last_rise_time_next;
  logic [TIME_W-1:0] leak_check_time_next;
  logic [MBAR_W-1:0] leak_check_pressure_next;

  logic              out_valid;
  logic              take;
  logic [P100_W-1:0] lower_thr;
  logic [P100_W-1:0] upper_thr;
  logic [P100_W-1:0] full_thr;
  logic              below_lower;
  logic              at_upper;
  logic              at_full;
  logic [MBAR_W:0]   drop_ref;

  assign item_ready = !out_valid || result.ready;
  assign take       = item_valid && item_ready;

  assign lower_thr = {{(P100_W-PCT_W){1'b0}}, cfg.lower_pct} *
                     {{(P100_W-MBAR_W){1'b0}}, full_scale};
  assign upper_thr = {{(P100_W-PCT_W){1'b0}}, cfg.upper_pct} *
                     {{(P100_W-MBAR_W){1'b0}}, full_scale};
  assign full_thr  = {{(P100_W-PCT_W){1'b0}}, FULL_PCT} *
                     {{(P100_W-MBAR_W){1'b0}}, full_scale};
  assign below_lower = item.pressure_x100 < lower_thr;
  assign at_upper    = item.pressure_x100 >= upper_thr;
  assign at_full     = item.pressure_x100 >= full_thr;
  assign drop_ref    = {1'b0, item.pressure} + {1'b0, cfg.leak_drop_mbar};

  always_comb begin
    pump_state_next          = pump_state;
    valve_state_next         = valve_state;
    use_state_next           = use_state;
    leak_state_next          = leak_state;
    cal_state_next           = cal_state;
    full_scale_next          = full_scale;
    peak_pressure_next       = peak_pressure;
    peak_fs_next             = peak_fs;
    last_use_time_next       = last_use_time;
    cal_start_time_next      = cal_start_time;
    last_rise_time_next      = last_rise_time;
    leak_check_time_next     = leak_check_time;
    leak_check_pressure_next = leak_check_pressure;

    if (item.mode) begin
      cal_state_next      = 1'b1;
      peak_pressure_next  = '0;
      peak_fs_next        = '0;
      cal_start_time_next = item.now_ms;
      last_rise_time_next = item.now_ms;
      valve_state_next    = 1'b0;
      pump_state_next     = 1'b1;
    end else if (item.fault) begin
      pump_state_next  = 1'b0;
      valve_state_next = 1'b0;
    end else if (cal_state) begin
      if (item.pressure > peak_pressure) begin
        peak_pressure_next  = item.pressure;
        peak_fs_next        = item.pressure_fs;
        last_rise_time_next = item.now_ms;
      end
      if (((item.now_ms - last_rise_time_next) > cfg.cal_idle_ms) ||
          ((item.now_ms - cal_start_time) > cfg.cal_limit_ms)) begin
        full_scale_next = peak_fs_next;
        cal_state_next  = 1'b0;
        pump_state_next = 1'b0;
      end
    end else if (full_scale != '0) begin
      if (below_lower) begin
        use_state_next     = 1'b1;
        last_use_time_next = item.now_ms;
        leak_state_next    = 1'b0;
        pump_state_next    = 1'b1;
        valve_state_next   = 1'b0;
      end else if (at_full && use_state) begin
        use_state_next  = 1'b0;
        pump_state_next = 1'b0;
      end
      if (!use_state_next &&
          ((item.now_ms - last_use_time_next) >= cfg.quiet_delay_ms)) begin
        if (at_upper && !valve_state_next) begin
          pump_state_next  = 1'b0;
          valve_state_next = 1'b1;
        end else if (!at_upper && !below_lower && valve_state_next) begin
          valve_state_next = 1'b0;
        end
      end
      if (!pump_state_next && !valve_state_next && !use_state_next) begin
        if ((item.now_ms - leak_check_time) >= cfg.leak_period_ms) begin
          if (({1'b0, leak_check_pressure} > drop_ref) && (leak_check_pressure != '0)) begin
            leak_state_next = 1'b1;
          end
          leak_check_pressure_next = item.pressure;
          leak_check_time_next     = item.now_ms;
        end
      end else begin
        leak_check_pressure_next = item.pressure;
        leak_check_time_next     = item.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_state          <= 1'b0;
      valve_state         <= 1'b0;
      use_state           <= 1'b0;
      leak_state          <= 1'b0;
      cal_state           <= 1'b0;
      full_scale          <= '0;
      peak_pressure       <= '0;
      peak_fs             <= '0;
      last_use_time       <= '0;
      cal_start_time      <= '0;
      last_rise_time      <= '0;
      leak_check_time     <= '0;
      leak_check_pressure <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (take) begin
        pump_state          <= pump_state_next;
        valve_state         <= valve_state_next;
        use_state           <= use_state_next;
        leak_state          <= leak_state_next;
        cal_state           <= cal_state_next;
        full_scale          <= full_scale_next;
        peak_pressure       <= peak_pressure_next;
        peak_fs             <= peak_fs_next;
        last_use_time       <= last_use_time_next;
        cal_start_time      <= cal_start_time_next;
        last_rise_time      <= last_rise_time_next;
        leak_check_time     <= leak_check_time_next;
        leak_check_pressure <= leak_check_pressure_next;
        out_valid           <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.pump_on         <= pump_state_next;
      result.valve_open      <= valve_state_next;
      result.in_use          <= use_state_next;
      result.leak_alarm      <= leak_state_next;
      result.calibrating     <= cal_state_next;
      result.sensor_fault    <= item.fault;
      result.pressure_mbar   <= item.pressure;
      result.full_scale_mbar <= full_scale_next;
    end
  end

  assign result.valid = out_valid;

  a_cal_start: assert property (@(posedge clk) disable iff (rst)
    take && item.mode |=> cal_state && pump_state && !valve_state && (peak_pressure == '0))
    else $error("calibration request did not start a run");

  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    take && !item.mode && item.fault |=> !pump_state && !valve_state)
    else $error("sensor fault left pump or valve on");

  a_fs_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(full_scale) && $stable(cal_state) && $stable(leak_check_time))
    else $error("controller state moved without an accepted request");

  a_fs_learn: assert property (@(posedge clk) disable iff (rst)
    take |=> $stable(full_scale) || ($past(cal_state) && !cal_state))
    else $error("full scale changed outside the end of calibration");

  a_result_match: assert property (@(posedge clk) disable iff (rst)
    take |=> result.valid && (result.calibrating == cal_state) &&
             (result.full_scale_mbar == full_scale))
    else $error("result register disagrees with controller state");

endmodule

### src/pump_pressure_controller.sv
// ----------------------------------------------------------------------------
// pump_pressure_controller
// Water pump pressure controller: sample conversion, sensor fault check,
// calibration, usage, standby valve and leak rules.
// ----------------------------------------------------------------------------
// One request enters per clock and passes through a request register, a
// millivolt stage (one reciprocal multiply), a millibar stage, and the
// controller state update that loads the result register. The state update
// takes a request while the result register is empty or being read, so
// requests stream back to back at one per clock; each stage holds its
// request only while the stage after it is full and stalled. Configuration
// sits behind an APB port, register i at byte address 4*i, always ready.
module pump_pressure_controller
  import ppc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
  input  logic              clk,
  input  logic              rst,
  ppc_in_if.sink            sample,
  ppc_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  conv_t item;
  logic  item_valid;
  logic  item_ready;

  ppc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppc_conv #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_conv (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  ppc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .result     (result)
  );

endmodule
